// ----- design/exl_pkg.sv -----
// ----------------------------------------------------------------------------
// exl_pkg
// Shared types, constants and character classes for the expression lexer.
// ----------------------------------------------------------------------------
`default_nettype none

package exl_pkg;

	// line limit; columns and lengths saturate here
	localparam int MAX_LINE = 4096;
	localparam int COL_W    = 13;
	localparam logic [COL_W-1:0] COL_MAX = COL_W'(MAX_LINE);

	// result slots per character
	localparam int NSLOT = 3;

	localparam logic [7:0] CH_DOT    = 8'h2E;
	localparam logic [7:0] CH_UNDER  = 8'h5F;
	localparam logic [7:0] CH_CARET  = 8'h5E;
	localparam logic [7:0] CH_EQUAL  = 8'h3D;
	localparam logic [7:0] CH_LPAREN = 8'h28;
	localparam logic [7:0] CH_RPAREN = 8'h29;
	localparam logic [7:0] CH_PLUS   = 8'h2B;
	localparam logic [7:0] CH_MINUS  = 8'h2D;
	localparam logic [7:0] CH_STAR   = 8'h2A;
	localparam logic [7:0] CH_SLASH  = 8'h2F;
	localparam logic [7:0] CH_BSLASH = 8'h5C;
	localparam logic [7:0] CH_SPACE  = 8'h20;
	localparam logic [7:0] CH_TAB    = 8'h09;

	typedef enum logic [1:0] {
		KIND_NONE  = 2'd0,
		KIND_NUM   = 2'd1,
		KIND_IDENT = 2'd2
	} run_kind_t;

	typedef enum logic [3:0] {
		TT_BAD    = 4'd0,
		TT_SPACE  = 4'd1,
		TT_LPAREN = 4'd2,
		TT_RPAREN = 4'd3,
		TT_PLUS   = 4'd4,
		TT_MINUS  = 4'd5,
		TT_STAR   = 4'd6,
		TT_SLASH  = 4'd7,
		TT_BSLASH = 4'd8,
		TT_CARET  = 4'd9,
		TT_EQUAL  = 4'd10,
		TT_PERIOD = 4'd11,
		TT_IDENT  = 4'd12,
		TT_NUMBER = 4'd13
	} tok_type_t;

	typedef struct packed {
		tok_type_t        ttype;
		logic [COL_W-1:0] start;
		logic [COL_W-1:0] len;
		logic             last;
	} token_t;

	// tokens closed by one character, in emission order
	typedef struct packed {
		logic [1:0]   count;
		token_t [2:0] tok;
	} tok_batch_t;

	function automatic logic [COL_W-1:0] sat_inc(input logic [COL_W-1:0] v);
		return (v >= COL_MAX) ? COL_MAX : v + COL_W'(1);
	endfunction

	function automatic logic is_digit(input logic [7:0] c);
		return (c >= 8'h30) && (c <= 8'h39);
	endfunction

	function automatic logic is_letter(input logic [7:0] c);
		return ((c >= 8'h41) && (c <= 8'h5A)) || ((c >= 8'h61) && (c <= 8'h7A));
	endfunction

	function automatic logic is_numeric(input logic [7:0] c);
		return is_digit(c) || (c == CH_DOT);
	endfunction

	function automatic logic is_ident_char(input logic [7:0] c);
		return is_letter(c) || is_digit(c) || (c == CH_UNDER);
	endfunction

	function automatic logic is_elem_op(input logic [7:0] c);
		return (c == CH_PLUS) || (c == CH_MINUS) || (c == CH_STAR) ||
			(c == CH_SLASH) || (c == CH_BSLASH) || (c == CH_CARET);
	endfunction

	function automatic tok_type_t single_type(input logic [7:0] c);
		tok_type_t t;
		unique case (c)
			CH_SPACE, CH_TAB: t = TT_SPACE;
			CH_LPAREN:        t = TT_LPAREN;
			CH_RPAREN:        t = TT_RPAREN;
			CH_PLUS:          t = TT_PLUS;
			CH_MINUS:         t = TT_MINUS;
			CH_STAR:          t = TT_STAR;
			CH_SLASH:         t = TT_SLASH;
			CH_BSLASH:        t = TT_BSLASH;
			CH_CARET:         t = TT_CARET;
			CH_EQUAL:         t = TT_EQUAL;
			default:          t = TT_BAD;
		endcase
		return t;
	endfunction

	function automatic tok_type_t run_type(input run_kind_t k, input logic dot_first);
		if (k == KIND_IDENT) begin
			return TT_IDENT;
		end
		return dot_first ? TT_PERIOD : TT_NUMBER;
	endfunction

endpackage

`default_nettype wire

// ----- design/exl_scan.sv -----
// ----------------------------------------------------------------------------
// exl_scan
// Input register, run state and token building for one character per cycle while the result slots take each batch.
// ----------------------------------------------------------------------------
`default_nettype none

module exl_scan (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire logic [7:0]         in_char,
	input  wire logic               in_eol,
	output logic                    batch_valid,
	output exl_pkg::tok_batch_t     batch,
	input  wire logic               batch_take
);
	import exl_pkg::*;

	logic             valid_s1;
	logic [7:0]       char_s1;
	logic             eol_s1;

	run_kind_t        kind_q;
	logic             sd_q;
	logic [COL_W-1:0] start_q;
	logic [COL_W-1:0] cnt_q;
	logic [COL_W-1:0] col_q;
	logic             pend_q;

	logic             advance;
	logic [COL_W-1:0] col;
	logic             a_close;
	logic [COL_W-1:0] cnt1;
	run_kind_t        kind1;
	logic             cont;
	logic             b_close;
	logic             single_v;
	run_kind_t        kind2;
	logic             sd2;
	logic [COL_W-1:0] start2;
	logic [COL_W-1:0] cnt2;
	logic             pend2;
	logic             eol_close;
	token_t           run_tok;
	token_t           dot_tok;
	token_t           tail_tok;
	logic             tail_v;
	tok_batch_t       b;

	assign advance     = valid_s1 && batch_take;
	assign in_ready    = !valid_s1 || batch_take;
	assign batch_valid = valid_s1;
	assign batch       = b;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			char_s1 <= in_char;
			eol_s1  <= in_eol;
		end
	end

	always_comb begin
		col  = sat_inc(col_q);
		// held dot followed by an element-wise operator splits off
		a_close = pend_q && (kind_q == KIND_NUM) && is_elem_op(char_s1);
		cnt1    = (pend_q && !a_close) ? sat_inc(cnt_q) : cnt_q;
		kind1   = a_close ? KIND_NONE : kind_q;
		cont    = ((kind1 == KIND_NUM) && is_numeric(char_s1)) ||
			((kind1 == KIND_IDENT) && is_ident_char(char_s1));
		b_close = !cont && (kind1 != KIND_NONE);

		single_v = 1'b0;
		pend2    = 1'b0;
		kind2    = kind1;
		sd2      = sd_q;
		start2   = start_q;
		cnt2     = cnt1;
		if (cont) begin
			if ((kind1 == KIND_NUM) && (char_s1 == CH_DOT) && !eol_s1) begin
				pend2 = 1'b1;
			end else begin
				cnt2 = sat_inc(cnt1);
			end
		end else if (is_numeric(char_s1)) begin
			kind2  = KIND_NUM;
			sd2    = (char_s1 == CH_DOT);
			start2 = col;
			cnt2   = COL_W'(1);
		end else if (is_letter(char_s1)) begin
			kind2  = KIND_IDENT;
			sd2    = 1'b0;
			start2 = col;
			cnt2   = COL_W'(1);
		end else begin
			kind2    = KIND_NONE;
			sd2      = 1'b0;
			cnt2     = '0;
			single_v = 1'b1;
		end
		eol_close = eol_s1 && (kind2 != KIND_NONE);

		run_tok.ttype = run_type(kind_q, sd_q);
		run_tok.start = start_q;
		run_tok.len   = cnt1;
		run_tok.last  = 1'b0;

		dot_tok.ttype = TT_PERIOD;
		dot_tok.start = col_q;
		dot_tok.len   = COL_W'(1);
		dot_tok.last  = 1'b0;

		// single token and line-end close never occur together
		tail_v = single_v || eol_close;
		tail_tok.last = 1'b0;
		if (single_v) begin
			tail_tok.ttype = single_type(char_s1);
			tail_tok.start = col;
			tail_tok.len   = COL_W'(1);
		end else begin
			tail_tok.ttype = run_type(kind2, sd2);
			tail_tok.start = start2;
			tail_tok.len   = cnt2;
		end

		b.tok[0] = tail_tok;
		b.tok[1] = tail_tok;
		b.tok[2] = tail_tok;
		if (a_close) begin
			b.tok[0] = run_tok;
			b.tok[1] = dot_tok;
			b.count  = 2'd2 + 2'(tail_v);
		end else if (b_close) begin
			b.tok[0] = run_tok;
			b.count  = 2'd1 + 2'(tail_v);
		end else begin
			b.count  = 2'(tail_v);
		end
		for (int i = 0; i < NSLOT; i++) begin
			b.tok[i].last = (2'(i) + 2'd1 == b.count);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kind_q  <= KIND_NONE;
			sd_q    <= 1'b0;
			start_q <= '0;
			cnt_q   <= '0;
			col_q   <= '0;
			pend_q  <= 1'b0;
		end else if (advance) begin
			start_q <= start2;
			if (eol_s1) begin
				kind_q <= KIND_NONE;
				sd_q   <= 1'b0;
				cnt_q  <= '0;
				col_q  <= '0;
				pend_q <= 1'b0;
			end else begin
				kind_q <= kind2;
				sd_q   <= sd2;
				cnt_q  <= cnt2;
				col_q  <= col;
				pend_q <= pend2;
			end
		end
	end

endmodule

`default_nettype wire

// ----- design/exl_out_buf.sv -----
// ----------------------------------------------------------------------------
// exl_out_buf
// Three-slot result register; takes a batch of tokens, sends one per cycle while the sink is ready.
// ----------------------------------------------------------------------------
`default_nettype none

module exl_out_buf (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               batch_valid,
	input  wire exl_pkg::tok_batch_t batch,
	output logic                    batch_take,
	output logic                    out_valid,
	input  wire logic               out_ready,
	output exl_pkg::token_t         out_tok
);
	import exl_pkg::*;

	logic [1:0] count_q;
	token_t     slot_q [NSLOT];
	token_t     shifted [NSLOT];
	logic       pop;
	logic [1:0] keep;
	logic [2:0] total;

	assign out_valid = (count_q != 2'd0);
	assign out_tok   = slot_q[0];
	assign pop       = out_valid && out_ready;
	assign keep      = count_q - 2'(pop);
	assign total     = 3'(keep) + 3'(batch.count);
	assign batch_take = batch_valid && (total <= 3'(NSLOT));

	always_comb begin
		shifted[0] = pop ? slot_q[1] : slot_q[0];
		shifted[1] = pop ? slot_q[2] : slot_q[1];
		shifted[2] = slot_q[2];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= 2'd0;
		end else begin
			count_q <= batch_take ? total[1:0] : keep;
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < NSLOT; i++) begin
			if (2'(i) < keep) begin
				slot_q[i] <= shifted[i];
			end else begin
				slot_q[i] <= batch.tok[2'(i) - keep];
			end
		end
	end

endmodule

`default_nettype wire

// ----- design/expression_char_lexer.sv -----
// ----------------------------------------------------------------------------
// expression_char_lexer
// Character-stream lexer for expression lines: one byte in, tokens out.
// ----------------------------------------------------------------------------
// Usage:
//  - s_* carries one character word per handshake; s_tlast flags the final
//    character of the line and closes any open run.
//  - m_* carries one token word per handshake: type, 1-based start column
//    and length. m_tlast is set on the last token caused by a character.
//  - A character may cause zero to three tokens (held dot split off, run
//    closed, single-character token or line-end close).
//  - Path: an accepted character passes the input register, then the result
//    slots, before its first token shows on m_*.
//  - Throughput: one character per cycle while each gives at most one token
//    and the sink keeps up. m_* moves one token a cycle; the input register
//    waits once the three result slots cannot take its batch.
//  - Sink stall: tokens wait in the result slots; the input register keeps
//    taking characters until the slots cannot hold the next batch.
//  - Reset (arst_n low) empties both stages and clears the column counter
//    and run state; the first character after reset is column 1.
//  - Columns and lengths saturate at the line limit of 4096.
// ----------------------------------------------------------------------------
`default_nettype none

module expression_char_lexer (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [7:0]  s_tdata,   // [7:0] character
	input  wire logic        s_tlast,   // end_of_line
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [31:0]      m_tdata,   // [3:0] token_type, [16:4] start_column,
	                                    // [29:17] token_length, [31:30] zero
	output logic             m_tlast    // last_result
);
	import exl_pkg::*;

	tok_batch_t batch;
	logic       batch_valid;
	logic       batch_take;
	token_t     out_tok;

	// run tracking and token building
	exl_scan u_scan (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (s_tvalid),
		.in_ready    (s_tready),
		.in_char     (s_tdata),
		.in_eol      (s_tlast),
		.batch_valid (batch_valid),
		.batch       (batch),
		.batch_take  (batch_take)
	);

	// result slots, one token per output word
	exl_out_buf u_out (
		.clk         (clk),
		.arst_n      (arst_n),
		.batch_valid (batch_valid),
		.batch       (batch),
		.batch_take  (batch_take),
		.out_valid   (m_tvalid),
		.out_ready   (m_tready),
		.out_tok     (out_tok)
	);

	assign m_tdata = {2'b00, out_tok.len, out_tok.start, out_tok.ttype};
	assign m_tlast = out_tok.last;

endmodule

`default_nettype wire

// ----- verif/expression_char_lexer_tb.sv -----
// ----------------------------------------------------------------------------
// expression_char_lexer_tb
// Self-checking bench: feeds character words into the lexer and compares every
// token word against a predictor of the run, column and held-dot rules. Runs
// one short directed line and random expression lines.
// ----------------------------------------------------------------------------

module expression_char_lexer_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import exl_pkg::*;

	localparam int HOLD_CYCLES = 400;   // long sink hold-off while the source keeps going
	localparam int DRAIN_WAIT  = 20;    // cycles waited after the last token
	localparam int ERR_PRINT   = 40;    // mismatch lines printed before going quiet

	typedef struct packed {
		logic [7:0] ch;
		logic       eol;
	} char_word_t;

	// DUT ports
	logic        clk      = 1'b0;
	logic        arst_n   = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata  = 8'h00;  // [7:0] character
	logic        s_tlast  = 1'b0;   // end_of_line
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [31:0] m_tdata;           // [3:0] token_type, [16:4] start_column,
	                                // [29:17] token_length, [31:30] zero
	logic        m_tlast;           // last_result

	expression_char_lexer dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
	end

	// ------------------------------------------------------------------------
	// Stores
	// ------------------------------------------------------------------------
	char_word_t char_q[$];     // character words waiting for the source
	token_t     token_q[$];    // tokens predicted, oldest first
	token_t     new_toks[$];   // tokens caused by the character being lexed
	logic [7:0] line_buf[$];   // line under construction
	int         err_count = 0;

	// ------------------------------------------------------------------------
	// Lexer predictor state (mirrors the block after reset)
	// ------------------------------------------------------------------------
	run_kind_t        lx_kind      = KIND_NONE;
	logic             lx_dot_first = 1'b0;   // open numeric run began with '.'
	logic [COL_W-1:0] lx_start     = '0;
	logic [COL_W-1:0] lx_count     = '0;     // run length, held dot excluded
	logic [COL_W-1:0] lx_col       = '0;     // column of the previous character
	logic             lx_dot_held  = 1'b0;

	function automatic logic [COL_W-1:0] bump(input logic [COL_W-1:0] v);
		return (v >= COL_MAX) ? COL_MAX : v + COL_W'(1);
	endfunction

	function automatic logic is_num_ch(input logic [7:0] c);
		return ((c >= 8'h30) && (c <= 8'h39)) || (c == CH_DOT);
	endfunction

	function automatic logic is_alpha_ch(input logic [7:0] c);
		return ((c >= 8'h41) && (c <= 8'h5A)) || ((c >= 8'h61) && (c <= 8'h7A));
	endfunction

	function automatic logic is_word_ch(input logic [7:0] c);
		return is_alpha_ch(c) || ((c >= 8'h30) && (c <= 8'h39)) || (c == CH_UNDER);
	endfunction

	// element-wise operators split a held dot off a number
	function automatic logic is_split_op(input logic [7:0] c);
		return (c == CH_PLUS) || (c == CH_MINUS) || (c == CH_STAR) ||
			(c == CH_SLASH) || (c == CH_BSLASH) || (c == CH_CARET);
	endfunction

	function automatic tok_type_t lone_type(input logic [7:0] c);
		tok_type_t t;
		case (c)
			CH_SPACE, CH_TAB: t = TT_SPACE;
			CH_LPAREN:        t = TT_LPAREN;
			CH_RPAREN:        t = TT_RPAREN;
			CH_PLUS:          t = TT_PLUS;
			CH_MINUS:         t = TT_MINUS;
			CH_STAR:          t = TT_STAR;
			CH_SLASH:         t = TT_SLASH;
			CH_BSLASH:        t = TT_BSLASH;
			CH_CARET:         t = TT_CARET;
			CH_EQUAL:         t = TT_EQUAL;
			default:          t = TT_BAD;
		endcase
		return t;
	endfunction

	task automatic emit_tok(input tok_type_t ty, input logic [COL_W-1:0] col,
			input logic [COL_W-1:0] len);
		token_t t;
		t.ttype = ty;
		t.start = col;
		t.len   = len;
		t.last  = 1'b0;
		new_toks.push_back(t);
	endtask

	// close whatever run is open
	task automatic flush_run();
		tok_type_t ty;
		if (lx_kind != KIND_NONE) begin
			if (lx_kind == KIND_IDENT) begin
				ty = TT_IDENT;
			end else if (lx_dot_first) begin
				ty = TT_PERIOD;
			end else begin
				ty = TT_NUMBER;
			end
			emit_tok(ty, lx_start, lx_count);
			lx_kind      = KIND_NONE;
			lx_dot_first = 1'b0;
			lx_count     = '0;
			lx_dot_held  = 1'b0;
		end
	endtask

	// Predict the tokens for one accepted character and queue them.
	task automatic lex_char(input logic [7:0] ch, input logic eol);
		logic [COL_W-1:0] held_col;
		logic             opens;
		held_col = lx_col;          // a held dot sat on the previous column
		lx_col   = bump(lx_col);
		opens    = 1'b1;
		new_toks.delete();

		// resolve a held dot: split off before an element-wise op, else keep it
		if (lx_dot_held) begin
			lx_dot_held = 1'b0;
			if (lx_kind == KIND_NUM && is_split_op(ch)) begin
				flush_run();
				emit_tok(TT_PERIOD, held_col, COL_W'(1));
			end else begin
				lx_count = bump(lx_count);
			end
		end

		if (lx_kind == KIND_NUM && is_num_ch(ch)) begin
			// a dot is held unless it ends the line
			if (ch == CH_DOT && !eol) begin
				lx_dot_held = 1'b1;
			end else begin
				lx_count = bump(lx_count);
			end
			opens = 1'b0;
		end else if (lx_kind == KIND_IDENT && is_word_ch(ch)) begin
			lx_count = bump(lx_count);
			opens    = 1'b0;
		end else begin
			flush_run();
		end

		if (opens) begin
			if (is_num_ch(ch)) begin
				lx_kind      = KIND_NUM;
				lx_dot_first = (ch == CH_DOT);
				lx_start     = lx_col;
				lx_count     = COL_W'(1);
			end else if (is_alpha_ch(ch)) begin
				lx_kind      = KIND_IDENT;
				lx_dot_first = 1'b0;
				lx_start     = lx_col;
				lx_count     = COL_W'(1);
			end else begin
				emit_tok(lone_type(ch), lx_col, COL_W'(1));
			end
		end

		// line end closes everything and restarts the column count
		if (eol) begin
			flush_run();
			lx_col      = '0;
			lx_dot_held = 1'b0;
		end

		if (new_toks.size() != 0) begin
			new_toks[new_toks.size()-1].last = 1'b1;
		end
		foreach (new_toks[i]) begin
			token_q.push_back(new_toks[i]);
		end
	endtask

	// ------------------------------------------------------------------------
	// Mismatch reporting
	// ------------------------------------------------------------------------
	task automatic report_mismatch(input string what);
		if (err_count < ERR_PRINT) begin
			$display("MISMATCH @%0t: %s", $realtime, what);
		end
		err_count++;
	endtask

	task automatic check_field(input string name, input int got, input int want);
		if (got != want) begin
			report_mismatch($sformatf("%s got %0d want %0d", name, got, want));
		end
	endtask

	// ------------------------------------------------------------------------
	// Source: bursts of random length, random gaps, fed from char_q.
	// Prediction runs at the edge that accepts the word.
	// ------------------------------------------------------------------------
	int         gap_left   = 0;
	int         burst_left = 1;
	logic       drv_busy;
	char_word_t drv_word;

	always @(posedge clk) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
		end else begin
			drv_busy = s_tvalid;
			if (s_tvalid && s_tready) begin
				lex_char(s_tdata, s_tlast);
				drv_busy = 1'b0;
			end
			if (!drv_busy) begin
				if (gap_left != 0) begin
					gap_left--;
				end else if (char_q.size() != 0) begin
					drv_word = char_q.pop_front();
					s_tdata <= drv_word.ch;
					s_tlast <= drv_word.eol;
					drv_busy = 1'b1;
					if (burst_left <= 1) begin
						// most bursts chain straight on, giving stretches with no gaps
						burst_left = $urandom_range(1, 24);
						gap_left   = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 6) : 0;
					end else begin
						burst_left--;
					end
				end
			end
			s_tvalid <= drv_busy;
		end
	end

	// ------------------------------------------------------------------------
	// Sink: stall pattern picked per window, plus one long hold-off
	// ------------------------------------------------------------------------
	logic hold_go    = 1'b0;
	int   hold_cnt   = 0;
	int   stall_mode = 0;
	int   stall_age  = 0;
	int   stall_tick = 0;

	always @(posedge clk) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else if (hold_go && hold_cnt < HOLD_CYCLES) begin
			hold_cnt++;
			m_tready <= 1'b0;
		end else begin
			if (stall_age == 0) begin
				stall_mode = $urandom_range(0, 3);
				stall_age  = $urandom_range(20, 80);
			end else begin
				stall_age--;
			end
			stall_tick++;
			case (stall_mode)
				0:       m_tready <= 1'b1;                          // free running
				1:       m_tready <= ($urandom_range(0, 1) == 1);   // coin toss
				2:       m_tready <= (stall_tick % 4 == 0);         // one in four
				default: m_tready <= stall_tick[0];                 // alternate
			endcase
		end
	end

	// ------------------------------------------------------------------------
	// Monitor: every accepted token word against the oldest prediction
	// ------------------------------------------------------------------------
	token_t mon_want;

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			if (token_q.size() == 0) begin
				report_mismatch($sformatf("unexpected token word %h last %b",
					m_tdata, m_tlast));
			end else begin
				mon_want = token_q.pop_front();
				check_field("token_type",   m_tdata[3:0],   int'(mon_want.ttype));
				check_field("start_column", m_tdata[16:4],  int'(mon_want.start));
				check_field("token_length", m_tdata[29:17], int'(mon_want.len));
				check_field("pad",          m_tdata[31:30], 0);
				check_field("last_result",  m_tlast,        int'(mon_want.last));
			end
		end
	end

	// ------------------------------------------------------------------------
	// Stimulus builders (all run on the falling edge, away from the source)
	// ------------------------------------------------------------------------
	task automatic put_ch(input logic [7:0] ch, input logic eol);
		char_word_t w;
		w.ch  = ch;
		w.eol = eol;
		char_q.push_back(w);
	endtask

	task automatic put_text(input string s, input logic eol_last);
		for (int i = 0; i < s.len(); i++) begin
			put_ch(s[i], eol_last && (i == s.len() - 1));
		end
	endtask

	task automatic put_line();
		foreach (line_buf[i]) begin
			put_ch(line_buf[i], i == line_buf.size() - 1);
		end
		line_buf.delete();
	endtask

	function automatic logic [7:0] rand_alpha();
		int r;
		r = $urandom_range(0, 51);
		return (r < 26) ? 8'(8'h41 + r) : 8'(8'h61 + r - 26);
	endfunction

	function automatic logic [7:0] rand_digit();
		return 8'(8'h30 + $urandom_range(0, 9));
	endfunction

	// 0..5 element-wise ops, then '=' '(' ')'
	function automatic logic [7:0] op_byte(input int i);
		logic [7:0] c;
		case (i)
			0:       c = CH_PLUS;
			1:       c = CH_MINUS;
			2:       c = CH_STAR;
			3:       c = CH_SLASH;
			4:       c = CH_BSLASH;
			5:       c = CH_CARET;
			6:       c = CH_EQUAL;
			7:       c = CH_LPAREN;
			default: c = CH_RPAREN;
		endcase
		return c;
	endfunction

	// Append one random lexeme. Mostly well-formed pieces; some noise bytes.
	task automatic add_token();
		int n;
		n = $urandom_range(1, 5);
		case ($urandom_range(0, 9))
			0, 1, 2: begin   // number with stray dots
				repeat (n) line_buf.push_back(($urandom_range(0, 3) == 0) ? CH_DOT : rand_digit());
			end
			3: begin         // number, trailing dot, element-wise op: dot splits off
				repeat (n) line_buf.push_back(rand_digit());
				line_buf.push_back(CH_DOT);
				line_buf.push_back(op_byte($urandom_range(0, 5)));
			end
			4, 5: begin      // identifier
				line_buf.push_back(rand_alpha());
				repeat ($urandom_range(0, 5)) begin
					case ($urandom_range(0, 3))
						0:       line_buf.push_back(rand_digit());
						1:       line_buf.push_back(CH_UNDER);
						default: line_buf.push_back(rand_alpha());
					endcase
				end
			end
			6:               line_buf.push_back(op_byte($urandom_range(0, 8)));
			7: begin
				repeat ($urandom_range(1, 2))
					line_buf.push_back(($urandom_range(0, 1) == 0) ? CH_SPACE : CH_TAB);
			end
			8:               line_buf.push_back(8'($urandom_range(0, 255)));
			default: begin   // dot-led run, typed as period
				line_buf.push_back(CH_DOT);
				repeat (n - 1) line_buf.push_back(rand_digit());
			end
		endcase
	endtask

	task automatic random_lines(input int target);
		int pushed;
		pushed = 0;
		while (pushed < target) begin
			repeat ($urandom_range(1, 8)) add_token();
			pushed += line_buf.size();
			put_line();
		end
	endtask

	// source and sink quiet, every predicted token seen
	task automatic wait_drained();
		while (char_q.size() != 0 || s_tvalid || token_q.size() != 0) begin
			@(negedge clk);
		end
	endtask

	// ------------------------------------------------------------------------
	// Test sequence
	// ------------------------------------------------------------------------
	initial begin
		@(negedge clk);
		while (!arst_n) @(negedge clk);

		// directed: bad bytes incl. zero and high bytes, identifier with '_'
		// and digit, tab, every single-char token, held dot split before an
		// op, held dot kept before a letter, dot-led run, dot on the line end
		put_ch(8'h00, 1'b0);
		put_ch(8'hFF, 1'b0);
		put_ch(8'h80, 1'b0);
		put_ch(8'h7F, 1'b0);
		put_text("a_9\t(", 1'b0);
		put_text("1.+2.x", 1'b0);
		put_text(")-*/\\^=", 1'b0);
		put_text(".5 7.", 1'b1);
		wait_drained();   // source holds until all tokens are back

		// sink goes quiet for a long stretch while lines keep coming
		hold_go = 1'b1;
		random_lines(85);
		wait_drained();

		random_lines(85);
		wait_drained();
		repeat (DRAIN_WAIT) @(negedge clk);

		if (err_count == 0) begin
			$display("expression_char_lexer regression: pass");
		end else begin
			$display("expression_char_lexer regression: fail");
		end
		$finish;
	end

	// watchdog, far beyond the slowest legal run
	initial begin
		#5_000_000;
		$display("expression_char_lexer regression: fail");
		$finish;
	end

endmodule
